// ----- hdl/scd_pkg.sv -----
// scd_pkg: types, widths and codes shared by the scope column decimator.
// Depends on nothing; every other file of the block refers to it by scoped name.
package scd_pkg;

   // field and register widths
   localparam int MODE_W   = 2;
   localparam int IDX12_W  = 12;
   localparam int END_W    = 13;
   localparam int SCALE_W  = 24;
   localparam int AMP_W    = 15;
   localparam int XY_W     = 16;
   localparam int POS_W    = 28;
   localparam int CNT_W    = 13;
   localparam int MUL_A_W  = 16;
   localparam int MUL_P_W  = MUL_A_W + SCALE_W;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 24;
   // (k << 16) + samples_per_px - 1, with k below 2^16
   localparam int PDIV_NUM_W = 33;
   localparam int ONE_PX     = 65536;

   // display modes
   localparam logic [MODE_W-1:0] MODE_NEAREST = 2'd0;
   localparam logic [MODE_W-1:0] MODE_AVERAGE = 2'd1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MODE           = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_SAMPLE   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_END_SAMPLE     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PX_PER_SAMPLE  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLES_PER_PX = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_PLOT_WIDTH     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_AMP_LIMIT      = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_PX_PER_AMP     = 3'd7;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [IDX12_W-1:0] first_sample;
      logic [END_W-1:0]   end_sample;
      logic [SCALE_W-1:0] px_per_sample;
      logic [SCALE_W-1:0] samples_per_px;
      logic [IDX12_W-1:0] plot_width;
      logic [AMP_W-1:0]   amp_limit;
      logic [SCALE_W-1:0] px_per_amp;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      mode:           2'd0,
      first_sample:   12'd0,
      end_sample:     13'd4096,
      px_per_sample:  24'd65536,
      samples_per_px: 24'd65536,
      plot_width:     12'd512,
      amp_limit:      15'd32767,
      px_per_amp:     24'd65536
   };

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREP,
      ST_YS,
      ST_YS_RD,
      ST_PDIV,
      ST_PDIV_W,
      ST_MAP,
      ST_MAP_RD,
      ST_POS,
      ST_POS_RD,
      ST_MDIV,
      ST_MDIV_W,
      ST_YA,
      ST_YA_RD,
      ST_EMIT,
      ST_OUT
   } state_type;

endpackage

// ----- hdl/scd_csr.sv -----
// scd_csr: configuration register bank of the scope column decimator.
// Depends on scd_pkg (cfg_type, register indexes, reset values).
module scd_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write,
   input  logic [scd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [scd_pkg::CSR_DAT_W-1:0]    csr_data,
   output scd_pkg::cfg_type                 cfg
);

   scd_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            scd_pkg::CSR_MODE:           cfg_in.mode           = csr_data[1:0];
            scd_pkg::CSR_FIRST_SAMPLE:   cfg_in.first_sample   = csr_data[11:0];
            scd_pkg::CSR_END_SAMPLE:     cfg_in.end_sample     = csr_data[12:0];
            scd_pkg::CSR_PX_PER_SAMPLE:  cfg_in.px_per_sample  = csr_data[23:0];
            scd_pkg::CSR_SAMPLES_PER_PX: cfg_in.samples_per_px = csr_data[23:0];
            scd_pkg::CSR_PLOT_WIDTH:     cfg_in.plot_width     = csr_data[11:0];
            scd_pkg::CSR_AMP_LIMIT:      cfg_in.amp_limit      = csr_data[14:0];
            scd_pkg::CSR_PX_PER_AMP:     cfg_in.px_per_amp     = csr_data[23:0];
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= scd_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- hdl/scd_mul.sv -----
// scd_mul: the shared 16 x 24 unsigned multiplier, product registered.
// Depends on scd_pkg (operand widths).
module scd_mul (
   input  logic                           clock,
   input  logic [scd_pkg::MUL_A_W-1:0]    mul_a,
   input  logic [scd_pkg::SCALE_W-1:0]    mul_b,
   output logic [scd_pkg::MUL_P_W-1:0]    mul_p
);

   logic [scd_pkg::MUL_P_W-1:0] prod_ff, prod_in;

   assign prod_in = scd_pkg::MUL_P_W'(mul_a) * scd_pkg::MUL_P_W'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign mul_p = prod_ff;

endmodule

// ----- hdl/scd_div.sv -----
// scd_div: shared restoring divider, one quotient bit per cycle.
// Depends on scd_pkg (divisor width); NUM_W is set by the top level.
module scd_div #(
   parameter int NUM_W = 33
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           div_start,
   input  logic [NUM_W-1:0]               div_num,
   input  logic [scd_pkg::SCALE_W-1:0]    div_den,
   output logic                           div_busy,
   output logic [NUM_W-1:0]               div_quo
);

   localparam int DEN_W = scd_pkg::SCALE_W;
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic [DEN_W:0]   rem_sh;
   logic [DEN_W:0]   rem_sub;
   logic             fits;

   // numerator bits shift out of the top of quo_ff as quotient bits shift in
   assign rem_sh  = {rem_ff, quo_ff[NUM_W-1]};
   assign rem_sub = rem_sh - {1'b0, den_ff};
   assign fits    = rem_sh >= {1'b0, den_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (div_start) begin
         quo_in  = div_num;
         rem_in  = '0;
         den_in  = div_den;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[NUM_W-2:0], fits};
         rem_in = fits ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign div_busy = busy_ff;
   assign div_quo  = quo_ff;

`ifndef SYNTH
   a_cnt_live: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (cnt_ff != '0))
      else $error("divider busy with an empty bit count");
   a_busy_drops: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !div_start && cnt_ff == CNT_W'(1)) |=> !busy_ff)
      else $error("divider ran past its last quotient bit");
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      div_start |=> (busy_ff && cnt_ff == CNT_W'(NUM_W)))
      else $error("divider did not load on start");
`endif

endmodule

// ----- hdl/scope_column_decimator.sv -----
// scope_column_decimator: top level; sequencer, frame and group state, point queue.
// Depends on scd_pkg, scd_csr, scd_mul and scd_div.
//
// Turns one channel of Q1.15 samples into display polyline points (x, y in Q12.4
// pixels) in nearest, average or peak mode. One sample is taken at a time and
// req_stall stays high until its points have gone out. Each sample runs through
// a small sequencer that drives one registered 16 x 24 multiplier and one
// restoring divider that resolves a quotient bit per cycle. A sample before
// first_sample stops after the prep state; one that only joins a group takes the
// row and position products; a peak-mode group close adds the amplitude product;
// a nearest-mode sample or an average-mode group close runs the divider too, whose
// NUM_W = max(33, SAMPLE_BITS + log2(FRAME_MAX) + 1) is 33 at the default sizes.
// A sample may cause two points: the frame's start point comes first.
module scope_column_decimator #(
   parameter int FRAME_MAX   = 4096,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [SAMPLE_BITS-1:0]     req_sample,
   input  logic                              req_frame_start,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [scd_pkg::XY_W-1:0]          rsp_x_pos,
   output logic [scd_pkg::XY_W-1:0]          rsp_y_pos,
   output logic                              rsp_last,
   input  logic                              csr_write,
   input  logic [scd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [scd_pkg::CSR_DAT_W-1:0]     csr_data
);

   localparam int SB     = SAMPLE_BITS;
   localparam int IW     = $clog2(FRAME_MAX + 1);
   localparam int KW     = $clog2(FRAME_MAX);
   localparam int CW     = (IW > scd_pkg::END_W) ? IW : scd_pkg::END_W;
   localparam int SUM_W  = SAMPLE_BITS + $clog2(FRAME_MAX) + 1;
   localparam int DIV_W  = (SUM_W > scd_pkg::PDIV_NUM_W) ? SUM_W : scd_pkg::PDIV_NUM_W;
   localparam int PW     = scd_pkg::IDX12_W;
   localparam int XW     = scd_pkg::XY_W;
   localparam int AW     = scd_pkg::AMP_W;
   localparam int PRW    = scd_pkg::MUL_P_W;
   localparam int POSW   = scd_pkg::POS_W;
   localparam int SCW    = scd_pkg::SCALE_W;
   localparam int CNTW   = scd_pkg::CNT_W;
   localparam logic [IW-1:0] FRAME_LIM = IW'(FRAME_MAX);

   scd_pkg::cfg_type   cfg;
   scd_pkg::state_type state_ff, state_in;

   // frame and group state
   logic [IW-1:0]           index_ff, index_in;
   logic [POSW-1:0]         anchor_ff, anchor_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [CNTW-1:0]         count_ff, count_in;
   logic signed [SB-1:0]    peak_ff, peak_in;
   logic [SB-1:0]           peak_mag_ff, peak_mag_in;
   logic [PW-1:0]           next_px_ff, next_px_in;
   logic                    open_ff, open_in;

   // per-sample working registers
   logic signed [SB-1:0]    sample_ff, sample_in;
   logic                    fs_ff, fs_in;
   logic [KW-1:0]           k_ff, k_in;
   logic                    start_pt_ff, start_pt_in;
   logic                    in_grp_ff, in_grp_in;
   logic                    last_idx_ff, last_idx_in;
   logic [XW-1:0]           ys_ff, ys_in;
   logic [PW-1:0]           p_ff, p_in;
   logic [XW-1:0]           pos_x_ff, pos_x_in;
   logic                    ym_neg_ff, ym_neg_in;
   logic [DIV_W-1:0]        ym_mag_ff, ym_mag_in;

   // point queue, two beats at most per sample
   logic [XW-1:0]           q_x_ff [2];
   logic [XW-1:0]           q_y_ff [2];
   logic [XW-1:0]           q_x_in [2];
   logic [XW-1:0]           q_y_in [2];
   logic [1:0]              q_n_ff, q_n_in;
   logic                    rd_ff, rd_in;

   // shared units
   logic [scd_pkg::MUL_A_W-1:0] mul_a;
   logic [SCW-1:0]              mul_b;
   logic [PRW-1:0]              mul_p;
   logic                        div_start;
   logic [DIV_W-1:0]            div_num;
   logic [SCW-1:0]              div_den;
   logic                        div_busy;
   logic [DIV_W-1:0]            div_quo;

   // combinational helpers
   logic [IW-1:0]    prep_idx;
   logic             prep_in_range;
   logic             prep_active;
   logic [CW-1:0]    end_eff;
   logic [CW-1:0]    idx_c;
   logic [SB-1:0]    s_mag;
   logic [SUM_W-1:0] sum_mag;
   logic [AW-1:0]    y_clamp;
   logic [XW-1:0]    y_arg;
   logic [XW-1:0]    y_sat;
   logic [POSW-1:0]  pos_sat;
   logic             close_now;
   logic [DIV_W-1:0] p_wide;
   logic             p_ok;
   logic             map_hit;
   logic             accept;
   logic             out_last;

   scd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   scd_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .mul_p (mul_p)
   );

   scd_div #(
      .NUM_W (DIV_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .div_start (div_start),
      .div_num   (div_num),
      .div_den   (div_den),
      .div_busy  (div_busy),
      .div_quo   (div_quo)
   );

   assign accept = req_valid && !req_stall;

   assign prep_idx      = fs_ff ? '0 : index_ff;
   assign prep_in_range = prep_idx < FRAME_LIM;
   assign idx_c         = CW'(prep_idx);
   assign prep_active   = prep_in_range && (idx_c >= CW'(cfg.first_sample));
   assign end_eff       = (CW'(cfg.end_sample) < CW'(FRAME_MAX)) ?
                          CW'(cfg.end_sample) : CW'(FRAME_MAX);

   assign s_mag   = sample_ff[SB-1] ? ($unsigned(~sample_ff) + SB'(1)) : $unsigned(sample_ff);
   assign sum_mag = sum_ff[SUM_W-1] ? ($unsigned(~sum_ff) + SUM_W'(1)) : $unsigned(sum_ff);

   // clamp to +-limit, then distance from the top of the plot
   assign y_clamp = (ym_mag_ff > DIV_W'(cfg.amp_limit)) ? cfg.amp_limit : ym_mag_ff[AW-1:0];
   assign y_arg   = ym_neg_ff ? (XW'(cfg.amp_limit) + XW'(y_clamp))
                              : (XW'(cfg.amp_limit) - XW'(y_clamp));
   assign y_sat   = (|mul_p[PRW-1:32]) ? '1 : mul_p[31:16];

   assign pos_sat   = (|mul_p[PRW-1:POSW]) ? '1 : mul_p[POSW-1:0];
   assign close_now = ({1'b0, pos_sat} >= ({1'b0, anchor_ff} + (POSW+1)'(scd_pkg::ONE_PX)))
                      || last_idx_ff;

   assign p_wide  = (cfg.samples_per_px == '0 || div_quo == '0) ? DIV_W'(1) : div_quo;
   assign p_ok    = p_wide < DIV_W'(cfg.plot_width);
   assign map_hit = (mul_p[PRW-1:16] == SCW'(k_ff)) && (p_ff >= next_px_ff);

   assign out_last = ({1'b0, rd_ff} == (q_n_ff - 2'd1));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         scd_pkg::ST_IDLE:   if (accept) state_in = scd_pkg::ST_PREP;
         scd_pkg::ST_PREP:   state_in = prep_active ? scd_pkg::ST_YS : scd_pkg::ST_IDLE;
         scd_pkg::ST_YS:     state_in = scd_pkg::ST_YS_RD;
         scd_pkg::ST_YS_RD: begin
            state_in = (cfg.mode == scd_pkg::MODE_NEAREST) ? scd_pkg::ST_PDIV
                                                           : scd_pkg::ST_POS;
         end
         scd_pkg::ST_PDIV:   state_in = scd_pkg::ST_PDIV_W;
         scd_pkg::ST_PDIV_W: begin
            if (!div_busy) state_in = p_ok ? scd_pkg::ST_MAP : scd_pkg::ST_POS;
         end
         scd_pkg::ST_MAP:    state_in = scd_pkg::ST_MAP_RD;
         scd_pkg::ST_MAP_RD: state_in = scd_pkg::ST_POS;
         scd_pkg::ST_POS: begin
            state_in = (in_grp_ff && open_ff) ? scd_pkg::ST_POS_RD : scd_pkg::ST_EMIT;
         end
         scd_pkg::ST_POS_RD: begin
            if (!close_now || cfg.mode == scd_pkg::MODE_NEAREST) begin
               state_in = scd_pkg::ST_EMIT;
            end else if (cfg.mode == scd_pkg::MODE_AVERAGE) begin
               state_in = scd_pkg::ST_MDIV;
            end else begin
               state_in = scd_pkg::ST_YA;
            end
         end
         scd_pkg::ST_MDIV:   state_in = scd_pkg::ST_MDIV_W;
         scd_pkg::ST_MDIV_W: if (!div_busy) state_in = scd_pkg::ST_YA;
         scd_pkg::ST_YA:     state_in = scd_pkg::ST_YA_RD;
         scd_pkg::ST_YA_RD:  state_in = scd_pkg::ST_EMIT;
         scd_pkg::ST_EMIT:   state_in = (q_n_ff == 2'd0) ? scd_pkg::ST_IDLE : scd_pkg::ST_OUT;
         scd_pkg::ST_OUT:    if (!rsp_stall && out_last) state_in = scd_pkg::ST_IDLE;
         default:            state_in = scd_pkg::ST_IDLE;
      endcase
   end

   // outputs and unit operands
   always_comb begin
      req_stall = (state_ff != scd_pkg::ST_IDLE);
      rsp_valid = (state_ff == scd_pkg::ST_OUT);
      div_start = (state_ff == scd_pkg::ST_PDIV) || (state_ff == scd_pkg::ST_MDIV);
      div_num   = (state_ff == scd_pkg::ST_MDIV) ? DIV_W'(sum_mag)
                : ((DIV_W'(k_ff) << 16) + DIV_W'(cfg.samples_per_px) - DIV_W'(1));
      div_den   = (state_ff == scd_pkg::ST_MDIV) ?
                  ((count_ff == '0) ? SCW'(1) : SCW'(count_ff)) : cfg.samples_per_px;
      unique case (state_ff)
         scd_pkg::ST_MAP: begin
            mul_a = scd_pkg::MUL_A_W'(p_ff);
            mul_b = cfg.samples_per_px;
         end
         scd_pkg::ST_POS: begin
            mul_a = scd_pkg::MUL_A_W'(k_ff);
            mul_b = cfg.px_per_sample;
         end
         default: begin
            mul_a = y_arg;
            mul_b = cfg.px_per_amp;
         end
      endcase
   end

   assign rsp_x_pos = q_x_ff[rd_ff];
   assign rsp_y_pos = q_y_ff[rd_ff];
   assign rsp_last  = out_last;

   // datapath register updates
   always_comb begin
      index_in    = index_ff;
      anchor_in   = anchor_ff;
      sum_in      = sum_ff;
      count_in    = count_ff;
      peak_in     = peak_ff;
      peak_mag_in = peak_mag_ff;
      next_px_in  = next_px_ff;
      open_in     = open_ff;
      sample_in   = sample_ff;
      fs_in       = fs_ff;
      k_in        = k_ff;
      start_pt_in = start_pt_ff;
      in_grp_in   = in_grp_ff;
      last_idx_in = last_idx_ff;
      ys_in       = ys_ff;
      p_in        = p_ff;
      pos_x_in    = pos_x_ff;
      ym_neg_in   = ym_neg_ff;
      ym_mag_in   = ym_mag_ff;
      q_x_in      = q_x_ff;
      q_y_in      = q_y_ff;
      q_n_in      = q_n_ff;
      rd_in       = rd_ff;

      unique case (state_ff)
         scd_pkg::ST_IDLE: begin
            if (accept) begin
               sample_in = req_sample;
               fs_in     = req_frame_start;
               q_n_in    = 2'd0;
               rd_in     = 1'b0;
            end
         end
         scd_pkg::ST_PREP: begin
            if (fs_ff) begin
               anchor_in   = '0;
               sum_in      = '0;
               count_in    = '0;
               peak_in     = '0;
               peak_mag_in = '0;
               next_px_in  = PW'(1);
               open_in     = 1'b0;
            end
            // the index sticks at the frame limit
            index_in    = prep_in_range ? (prep_idx + IW'(1)) : prep_idx;
            k_in        = KW'(idx_c - CW'(cfg.first_sample));
            start_pt_in = (idx_c == CW'(cfg.first_sample));
            in_grp_in   = idx_c < end_eff;
            last_idx_in = (idx_c + CW'(1)) == end_eff;
            ym_neg_in   = sample_ff[SB-1];
            ym_mag_in   = DIV_W'(s_mag);
         end
         scd_pkg::ST_YS_RD: begin
            ys_in = y_sat;
            if (start_pt_ff) begin
               q_x_in[q_n_ff[0]] = '0;
               q_y_in[q_n_ff[0]] = y_sat;
               q_n_in            = q_n_ff + 2'd1;
            end
         end
         scd_pkg::ST_PDIV_W: begin
            if (!div_busy) p_in = p_wide[PW-1:0];
         end
         scd_pkg::ST_MAP_RD: begin
            if (map_hit) begin
               q_x_in[q_n_ff[0]] = {p_ff, 4'b0000};
               q_y_in[q_n_ff[0]] = ys_ff;
               q_n_in            = q_n_ff + 2'd1;
               next_px_in        = p_ff + PW'(1);
            end
         end
         scd_pkg::ST_POS: begin
            if (in_grp_ff) begin
               if (!open_ff) begin
                  // a group cannot open on the last shown sample
                  if (!last_idx_ff) begin
                     open_in     = 1'b1;
                     sum_in      = SUM_W'(sample_ff);
                     count_in    = CNTW'(1);
                     peak_in     = sample_ff;
                     peak_mag_in = s_mag;
                  end
               end else begin
                  sum_in   = sum_ff + SUM_W'(sample_ff);
                  count_in = count_ff + CNTW'(1);
                  if (s_mag > peak_mag_ff) begin
                     peak_in     = sample_ff;
                     peak_mag_in = s_mag;
                  end
               end
            end
         end
         scd_pkg::ST_POS_RD: begin
            if (close_now) begin
               open_in   = 1'b0;
               anchor_in = pos_sat;
               pos_x_in  = pos_sat[POSW-1:POSW-XW];
               ym_neg_in = peak_ff[SB-1];
               ym_mag_in = DIV_W'(peak_mag_ff);
            end
         end
         scd_pkg::ST_MDIV_W: begin
            if (!div_busy) begin
               ym_neg_in = sum_ff[SUM_W-1];
               ym_mag_in = div_quo;
            end
         end
         scd_pkg::ST_YA_RD: begin
            q_x_in[q_n_ff[0]] = pos_x_ff;
            q_y_in[q_n_ff[0]] = y_sat;
            q_n_in            = q_n_ff + 2'd1;
         end
         scd_pkg::ST_OUT: begin
            if (!rsp_stall && !out_last) rd_in = 1'b1;
         end
         default: begin
            rd_in = rd_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= scd_pkg::ST_IDLE;
         index_ff    <= '0;
         anchor_ff   <= '0;
         sum_ff      <= '0;
         count_ff    <= '0;
         peak_ff     <= '0;
         peak_mag_ff <= '0;
         next_px_ff  <= PW'(1);
         open_ff     <= 1'b0;
         q_n_ff      <= 2'd0;
         rd_ff       <= 1'b0;
      end else begin
         state_ff    <= state_in;
         index_ff    <= index_in;
         anchor_ff   <= anchor_in;
         sum_ff      <= sum_in;
         count_ff    <= count_in;
         peak_ff     <= peak_in;
         peak_mag_ff <= peak_mag_in;
         next_px_ff  <= next_px_in;
         open_ff     <= open_in;
         q_n_ff      <= q_n_in;
         rd_ff       <= rd_in;
      end
      sample_ff   <= sample_in;
      fs_ff       <= fs_in;
      k_ff        <= k_in;
      start_pt_ff <= start_pt_in;
      in_grp_ff   <= in_grp_in;
      last_idx_ff <= last_idx_in;
      ys_ff       <= ys_in;
      p_ff        <= p_in;
      pos_x_ff    <= pos_x_in;
      ym_neg_ff   <= ym_neg_in;
      ym_mag_ff   <= ym_mag_in;
      q_x_ff      <= q_x_in;
      q_y_ff      <= q_y_in;
   end

`ifndef SYNTH
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("point beat offered while a new sample could be taken");
   a_queue_sane: assert property (@(posedge clock) disable iff (reset)
      (state_ff == scd_pkg::ST_OUT) |-> (q_n_ff != 2'd0 && q_n_ff != 2'd3
                                         && {1'b0, rd_ff} < q_n_ff))
      else $error("point queue read outside its fill");
   a_div_free: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy)
      else $error("divider restarted while still busy");
   a_ready_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_last) |=> !req_stall)
      else $error("block did not free up after the final beat");
`endif

endmodule

// ----- tb/testbench.sv -----
// testbench: self-checking bench for scope_column_decimator, one file.
// Depends on scd_pkg and the block's RTL; a scoreboard class predicts every point beat
// and plain tasks drive the sample and register ports, an always block the point stall.
module testbench;

   localparam int FRAME_LEN      = 4096;
   localparam int SETTLE_CYCLES  = 120;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int NUM_PHASES     = 14;
   localparam int PHASE_BEATS    = 60;

   localparam logic [scd_pkg::MODE_W-1:0] MODE_PEAK  = 2'd2;
   localparam logic [scd_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;
   localparam longint unsigned POS_MAX = 64'h0FFF_FFFF;

   typedef struct packed {
      logic [scd_pkg::XY_W-1:0] x_pos;
      logic [scd_pkg::XY_W-1:0] y_pos;
      logic                     last;
   } point_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_stall;
   logic signed [15:0]               req_sample = '0;
   logic                             req_frame_start = 1'b0;
   logic                             rsp_valid;
   logic                             rsp_stall = 1'b0;
   logic [scd_pkg::XY_W-1:0]         rsp_x_pos;
   logic [scd_pkg::XY_W-1:0]         rsp_y_pos;
   logic                             rsp_last;
   logic                             csr_write = 1'b0;
   logic [scd_pkg::CSR_IDX_W-1:0]    csr_index = '0;
   logic [scd_pkg::CSR_DAT_W-1:0]    csr_data = '0;

   scope_column_decimator #(
      .FRAME_MAX   (FRAME_LEN),
      .SAMPLE_BITS (16)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_sample      (req_sample),
      .req_frame_start (req_frame_start),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_x_pos       (rsp_x_pos),
      .rsp_y_pos       (rsp_y_pos),
      .rsp_last        (rsp_last),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   class point_scoreboard;
      scd_pkg::cfg_type cfg;
      int unsigned      sample_index;
      longint unsigned  anchor_pos;
      longint           group_sum;
      logic [12:0]      group_count;
      longint           peak_value;
      longint           peak_magnitude;
      logic [11:0]      next_pixel;
      bit               group_open;
      point_type        expected_points[$];
      int               mismatches;

      function new();
         cfg = scd_pkg::CFG_RESET;
         sample_index = 0;
         mismatches = 0;
         clear_frame();
      endfunction

      function void clear_frame();
         anchor_pos = 0;
         group_sum = 0;
         group_count = '0;
         peak_value = 0;
         peak_magnitude = 0;
         next_pixel = 12'd1;
         group_open = 1'b0;
      endfunction

      function void set_register(logic [scd_pkg::CSR_IDX_W-1:0] idx,
                                 logic [scd_pkg::CSR_DAT_W-1:0] d);
         case (idx)
            scd_pkg::CSR_MODE:           cfg.mode = d[1:0];
            scd_pkg::CSR_FIRST_SAMPLE:   cfg.first_sample = d[11:0];
            scd_pkg::CSR_END_SAMPLE:     cfg.end_sample = d[12:0];
            scd_pkg::CSR_PX_PER_SAMPLE:  cfg.px_per_sample = d;
            scd_pkg::CSR_SAMPLES_PER_PX: cfg.samples_per_px = d;
            scd_pkg::CSR_PLOT_WIDTH:     cfg.plot_width = d[11:0];
            scd_pkg::CSR_AMP_LIMIT:      cfg.amp_limit = d[14:0];
            default:                     cfg.px_per_amp = d;
         endcase
      endfunction

      // amplitude to screen row: clamp, offset from the top, scale, saturate
      function logic [15:0] y_for(longint amp);
         longint          lim;
         longint          c;
         longint unsigned y;
         lim = cfg.amp_limit;
         c = amp;
         if (c > lim) c = lim;
         if (c < -lim) c = -lim;
         y = longint'(lim - c) * longint'(cfg.px_per_amp);
         y = y >> 16;
         return (y > 65535) ? 16'hFFFF : y[15:0];
      endfunction

      // returns 1 when the sample reached the column logic at all
      function bit note_sample(logic signed [15:0] smp, logic fs);
         longint          s;
         longint          a;
         longint          mag;
         longint          cnt;
         longint unsigned p;
         longint unsigned mapped;
         longint unsigned pos;
         int unsigned     idx;
         int unsigned     k;
         int unsigned     endv;
         point_type       pts [2];
         int              n;
         s = smp;
         n = 0;
         if (fs) begin
            sample_index = 0;
            clear_frame();
         end
         idx = sample_index;
         if (idx >= FRAME_LEN) return 1'b0;
         sample_index = idx + 1;
         if (idx < cfg.first_sample) return 1'b0;
         k = idx - cfg.first_sample;
         endv = (cfg.end_sample < FRAME_LEN) ? cfg.end_sample : FRAME_LEN;

         if (k == 0) begin
            pts[n] = '{16'd0, y_for(s), 1'b0};
            n++;
         end

         if (cfg.mode == scd_pkg::MODE_NEAREST) begin
            if (cfg.samples_per_px == 0) begin
               p = 1;
               mapped = 0;
            end else begin
               p = ((longint'(k) << 16) + cfg.samples_per_px - 1) / cfg.samples_per_px;
               if (p < 1) p = 1;
               mapped = (p * cfg.samples_per_px) >> 16;
            end
            if (p < cfg.plot_width && mapped == k && p >= next_pixel) begin
               pts[n] = '{{p[11:0], 4'd0}, y_for(s), 1'b0};
               n++;
               next_pixel = p[11:0] + 12'd1;
            end
         end

         // group bookkeeping runs in every mode so a mode change mid-frame is clean
         if (endv > 0 && idx <= endv - 1) begin
            if (!group_open) begin
               if (idx < endv - 1) begin
                  group_open = 1'b1;
                  group_sum = s;
                  group_count = 13'd1;
                  peak_value = s;
                  peak_magnitude = (s < 0) ? -s : s;
               end
            end else begin
               pos = longint'(k) * cfg.px_per_sample;
               if (pos > POS_MAX) pos = POS_MAX;
               group_sum += s;
               group_count = group_count + 13'd1;
               mag = (s < 0) ? -s : s;
               if (mag > peak_magnitude) begin
                  peak_value = s;
                  peak_magnitude = mag;
               end
               if (pos >= anchor_pos + scd_pkg::ONE_PX || idx == endv - 1) begin
                  group_open = 1'b0;
                  anchor_pos = pos;
                  if (cfg.mode != scd_pkg::MODE_NEAREST) begin
                     if (cfg.mode == scd_pkg::MODE_AVERAGE) begin
                        cnt = longint'(group_count);
                        if (cnt == 0) cnt = 1;
                        a = group_sum / cnt;
                     end else begin
                        a = peak_value;
                     end
                     pts[n] = '{pos[27:12], y_for(a), 1'b0};
                     n++;
                  end
               end
            end
         end

         if (n > 0) pts[n-1].last = 1'b1;
         for (int i = 0; i < n; i++) expected_points.push_back(pts[i]);
         return 1'b1;
      endfunction

      function void check_point(logic [15:0] x, logic [15:0] y, logic last);
         point_type e;
         if (expected_points.size() == 0) begin
            $display("%0t: point beat with nothing expected: x %0d y %0d last %0d",
                     $time, x, y, last);
            mismatches++;
            return;
         end
         e = expected_points.pop_front();
         if (x !== e.x_pos) begin
            $display("%0t: x_pos expected %0d actual %0d", $time, e.x_pos, x);
            mismatches++;
         end
         if (y !== e.y_pos) begin
            $display("%0t: y_pos expected %0d actual %0d", $time, e.y_pos, y);
            mismatches++;
         end
         if (last !== e.last) begin
            $display("%0t: last expected %0d actual %0d", $time, e.last, last);
            mismatches++;
         end
      endfunction

      function int pending();
         return expected_points.size();
      endfunction

      function void check_drained();
         if (expected_points.size() != 0) begin
            $display("%0t: %0d point beats never arrived", $time, expected_points.size());
            mismatches++;
         end
      endfunction
   endclass

   point_scoreboard sb;
   int unsigned     burst_left = 0;
   int unsigned     used_beats = 0;
   int unsigned     rx_run = 0;
   int unsigned     quiet_cycles = 0;

   always #1 clock = ~clock;

   // receiver: stall runs, each followed by a free run, and now and then a long free stretch
   always @(posedge clock) begin
      if (rx_run == 0) begin
         if (!rsp_stall && $urandom_range(0, 2) != 0) begin
            rsp_stall <= 1'b1;
            rx_run = $urandom_range(1, 20);
         end else begin
            rsp_stall <= 1'b0;
            rx_run = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
                                                  : $urandom_range(1, 30);
         end
      end else begin
         rx_run--;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_point(rsp_x_pos, rsp_y_pos, rsp_last);
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no beat for %0d cycles", $time, quiet_cycles);
         $display("scope_column_decimator test failed");
         $finish;
      end
   end

   task automatic write_register(logic [scd_pkg::CSR_IDX_W-1:0] idx,
                                 logic [scd_pkg::CSR_DAT_W-1:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      sb.set_register(idx, value);
   endtask

   task automatic program_registers(scd_pkg::cfg_type c);
      write_register(scd_pkg::CSR_MODE, scd_pkg::CSR_DAT_W'(c.mode));
      write_register(scd_pkg::CSR_FIRST_SAMPLE, scd_pkg::CSR_DAT_W'(c.first_sample));
      write_register(scd_pkg::CSR_END_SAMPLE, scd_pkg::CSR_DAT_W'(c.end_sample));
      write_register(scd_pkg::CSR_PX_PER_SAMPLE, c.px_per_sample);
      write_register(scd_pkg::CSR_SAMPLES_PER_PX, c.samples_per_px);
      write_register(scd_pkg::CSR_PLOT_WIDTH, scd_pkg::CSR_DAT_W'(c.plot_width));
      write_register(scd_pkg::CSR_AMP_LIMIT, scd_pkg::CSR_DAT_W'(c.amp_limit));
      write_register(scd_pkg::CSR_PX_PER_AMP, c.px_per_amp);
      csr_write <= 1'b0;
   endtask

   // sender works in bursts; valid drops only between bursts
   task automatic send_sample(logic signed [15:0] s, logic fs);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 25);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_sample <= s;
      req_frame_start <= fs;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (sb.note_sample(s, fs)) used_beats++;
   endtask

   // hold off until every point is out, then let any silent work finish
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      burst_left = 0;
   endtask

   function automatic logic [scd_pkg::SCALE_W-1:0] pick_scale();
      case ($urandom_range(0, 7))
         0:       return 24'd0;
         1:       return 24'd1;
         2:       return 24'hFFFFFF;
         3:       return 24'h010000;
         default: return 24'($urandom_range(24'h002000, 24'h040000));
      endcase
   endfunction

   function automatic logic [15:0] pick_sample();
      logic [15:0] lim;
      lim = 16'(sb.cfg.amp_limit);
      case ($urandom_range(0, 9))
         0:       return 16'h7FFF;
         1:       return 16'h8000;
         2:       return 16'($urandom_range(0, 2) - 1);
         3:       return 16'(lim + $urandom_range(0, 4) - 2);
         4:       return 16'(-lim + $urandom_range(0, 4) - 2);
         default: return 16'($urandom());
      endcase
   endfunction

   function automatic scd_pkg::cfg_type pick_settings(int ph);
      scd_pkg::cfg_type c;
      case (ph % 4)
         0:       c.mode = scd_pkg::MODE_NEAREST;
         1:       c.mode = scd_pkg::MODE_AVERAGE;
         2:       c.mode = MODE_PEAK;
         default: c.mode = MODE_SPARE;
      endcase
      c.first_sample = 12'($urandom_range(0, 6));
      c.end_sample = 13'(c.first_sample + $urandom_range(1, 60));
      c.px_per_sample = pick_scale();
      c.samples_per_px = pick_scale();
      case ($urandom_range(0, 5))
         0:       c.plot_width = 12'd0;
         1:       c.plot_width = 12'd1;
         2:       c.plot_width = 12'hFFF;
         default: c.plot_width = 12'($urandom_range(2, 80));
      endcase
      case ($urandom_range(0, 5))
         0:       c.amp_limit = 15'd0;
         1:       c.amp_limit = 15'd1;
         2:       c.amp_limit = 15'h7FFF;
         default: c.amp_limit = 15'($urandom_range(1, 32767));
      endcase
      c.px_per_amp = pick_scale();
      case (ph)
         0: begin
            c.first_sample = 12'd0;
            c.end_sample = 13'h1FFF;
            c.px_per_sample = 24'hFFFFFF;
            c.samples_per_px = 24'hFFFFFF;
            c.plot_width = 12'hFFF;
            c.amp_limit = 15'h7FFF;
            c.px_per_amp = 24'hFFFFFF;
         end
         1: begin
            // zero scales: groups close only on the frame's last shown sample
            c.px_per_sample = 24'd0;
            c.samples_per_px = 24'd0;
            c.amp_limit = 15'd0;
            c.px_per_amp = 24'd0;
            c.plot_width = 12'd1;
         end
         2: begin
            c.first_sample = 12'd10;
            c.end_sample = 13'($urandom_range(0, 10));
         end
         NUM_PHASES - 1: begin
            // end at or beyond the frame: the frame limit takes over
            c.end_sample = ($urandom_range(0, 1) == 0) ? 13'h1FFF : 13'd4096;
         end
         default: ;
      endcase
      return c;
   endfunction

   task automatic run_directed();
      scd_pkg::cfg_type c;
      logic [15:0]      vals[$];
      c = scd_pkg::CFG_RESET;
      c.mode = MODE_PEAK;
      c.end_sample = 13'd10;
      c.px_per_sample = 24'h008000;
      program_registers(c);
      // equal magnitudes of opposite sign: the earlier one must win
      vals = '{16'h7FFF, 16'h8000, 16'd5, 16'hFFFB, 16'd0,
               16'hFFFF, 16'd1, 16'h7FFF, 16'h8000, 16'd100};
      foreach (vals[i]) send_sample(vals[i], i == 0);
      settle();
      c.mode = scd_pkg::MODE_AVERAGE;
      c.first_sample = 12'd1;
      c.end_sample = 13'd7;
      program_registers(c);
      vals = '{16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'd1, 16'hFFFF, 16'd0};
      foreach (vals[i]) send_sample(vals[i], i == 0);
      settle();
      c.mode = scd_pkg::MODE_NEAREST;
      c.first_sample = 12'd0;
      c.end_sample = 13'd4096;
      c.samples_per_px = 24'h018000;
      c.plot_width = 12'd4;
      program_registers(c);
      vals = '{16'h7FFF, 16'h8000, 16'h5555, 16'hAAAA, 16'd0, 16'hFFFF, 16'd1, 16'h1234};
      foreach (vals[i]) send_sample(vals[i], i == 0);
      settle();
   endtask

   task automatic run_phase(int ph);
      int unsigned start;
      int unsigned len;
      bit          broken;
      bit          fs;
      program_registers(pick_settings(ph));
      start = used_beats;
      while (used_beats - start < PHASE_BEATS) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 40);
         broken = ($urandom_range(0, 5) == 0);
         for (int i = 0; i < len; i++) begin
            if (i == 0)
               fs = ($urandom_range(0, 9) != 0);
            else
               fs = broken && ($urandom_range(0, 15) == 0);
            send_sample(pick_sample(), fs);
         end
         if ($urandom_range(0, 30) == 0) settle();
      end
      settle();
   endtask

   initial begin
      sb = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      for (int ph = 0; ph < NUM_PHASES; ph++) run_phase(ph);
      settle();
      sb.check_drained();
      if (sb.mismatches == 0)
         $display("scope_column_decimator test passed");
      else
         $display("scope_column_decimator test failed");
      $finish;
   end

endmodule
